### rtl/ckm_pkg.sv
// ckm_pkg: shared constants, status codes and the command name ROM
// for the command keyword matcher. No dependencies.
package ckm_pkg;

    localparam int LineMaxDefault     = 32;
    localparam int NumCommandsDefault = 17;
    localparam int NameMaxDefault     = 10;
    localparam int QueueDepthDefault  = 2;

    localparam int NameBytes = 10;

    localparam logic [7:0] CharNewline = 8'h0A;
    localparam logic [7:0] CharLowA    = 8'h61;
    localparam logic [7:0] CharLowZ    = 8'h7A;
    localparam logic [7:0] CharUpA     = 8'h41;
    localparam logic [7:0] CharUpZ     = 8'h5A;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharNine    = 8'h39;
    localparam logic [7:0] CaseOffset  = 8'd32;

    typedef enum logic [1:0] {
        ST_EMPTY     = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_OVERSHOOT = 2'd3
    } line_status_t;

    // names are right-justified in the vector, first character highest
    function automatic logic [NameBytes*8-1:0] cmd_name(int k);
        case (k)
            0:       return (NameBytes*8)'("5V");
            1:       return (NameBytes*8)'("VBAT");
            2:       return (NameBytes*8)'("GPSON");
            3:       return (NameBytes*8)'("GPSOFF");
            4:       return (NameBytes*8)'("GPSSENDOFF");
            5:       return (NameBytes*8)'("GPSFAST");
            6:       return (NameBytes*8)'("GPSSLOW");
            7:       return (NameBytes*8)'("GPSBAUD");
            8:       return (NameBytes*8)'("RFRST");
            9:       return (NameBytes*8)'("RFI");
            10:      return (NameBytes*8)'("RFREAD");
            11:      return (NameBytes*8)'("RFSEND");
            12:      return (NameBytes*8)'("RFWAIT");
            13:      return (NameBytes*8)'("RFSLAVE");
            14:      return (NameBytes*8)'("RFMASTER");
            15:      return (NameBytes*8)'("PRINTCMD");
            16:      return (NameBytes*8)'("HELP");
            default: return '0;
        endcase
    endfunction

    function automatic int name_len(int k);
        case (k)
            0:       return 2;
            1:       return 4;
            2:       return 5;
            3:       return 6;
            4:       return 10;
            5:       return 7;
            6:       return 7;
            7:       return 7;
            8:       return 5;
            9:       return 3;
            10:      return 6;
            11:      return 6;
            12:      return 6;
            13:      return 7;
            14:      return 8;
            15:      return 8;
            16:      return 4;
            default: return 0;
        endcase
    endfunction

    function automatic int eff_len(int k, int name_max);
        return (name_len(k) < name_max) ? name_len(k) : name_max;
    endfunction

    function automatic logic [7:0] name_char(int k, int p);
        logic [NameBytes*8-1:0] s;
        int l;
        s = cmd_name(k);
        l = name_len(k);
        if (p >= 0 && p < l)
        begin
            return s[8*(l-1-p) +: 8];
        end
        return 8'h00;
    endfunction

endpackage

### rtl/ckm_front.sv
// ckm_front: accepts characters, folds case, tracks the line state and
// the mask of still-matching commands; pushes one record per line.
// Depends on ckm_pkg.
module ckm_front #(
    parameter int LINE_MAX     = ckm_pkg::LineMaxDefault,
    parameter int NUM_COMMANDS = ckm_pkg::NumCommandsDefault,
    parameter int NAME_MAX     = ckm_pkg::NameMaxDefault,
    localparam int CntW = $clog2(LINE_MAX + 2),
    localparam int RecW = 1 + CntW + NUM_COMMANDS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      char_code,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            q_full,
    output logic            push,
    output logic [RecW-1:0] push_data
);

    localparam logic [CntW-1:0] LineMaxC = CntW'(LINE_MAX);

    logic [NUM_COMMANDS-1:0] mask_reg, mask_next;
    logic [CntW-1:0]         count_reg, count_next;
    logic [CntW-1:0]         tlen_reg, tlen_next;
    logic                    open_reg, open_next;

    logic                    accept;
    logic                    is_nl;
    logic [7:0]              c_up;
    logic                    is_tok;
    logic [NUM_COMMANDS-1:0] keep;

    assign is_nl    = (char_code == ckm_pkg::CharNewline);
    assign in_ready = !q_full || !is_nl;
    assign accept   = in_valid && in_ready;
    assign push     = accept && is_nl;
    assign push_data = {(count_reg > LineMaxC), tlen_reg, mask_reg};

    assign c_up = (char_code >= ckm_pkg::CharLowA && char_code <= ckm_pkg::CharLowZ)
                  ? (char_code - ckm_pkg::CaseOffset) : char_code;
    assign is_tok = (c_up >= ckm_pkg::CharUpA && c_up <= ckm_pkg::CharUpZ)
                 || (c_up >= ckm_pkg::CharZero && c_up <= ckm_pkg::CharNine);

    for (genvar k = 0; k < NUM_COMMANDS; k++)
    begin : g_cmp
        localparam int EffLen = ckm_pkg::eff_len(k, NAME_MAX);
        assign keep[k] = (tlen_reg < CntW'(EffLen))
                      && (ckm_pkg::name_char(k, int'(tlen_reg)) == c_up);
    end

    always_comb
    begin
        mask_next  = mask_reg;
        count_next = count_reg;
        tlen_next  = tlen_reg;
        open_next  = open_reg;
        if (accept)
        begin
            if (is_nl)
            begin
                mask_next  = '1;
                count_next = '0;
                tlen_next  = '0;
                open_next  = 1'b1;
            end
            else if (count_reg < LineMaxC)
            begin
                count_next = count_reg + 1'b1;
                if (open_reg)
                begin
                    if (is_tok)
                    begin
                        mask_next = mask_reg & keep;
                        tlen_next = tlen_reg + 1'b1;
                    end
                    else
                    begin
                        open_next = 1'b0;
                    end
                end
            end
            else if (count_reg == LineMaxC)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '1;
            count_reg <= '0;
            tlen_reg  <= '0;
            open_reg  <= 1'b1;
        end
        else
        begin
            mask_reg  <= mask_next;
            count_reg <= count_next;
            tlen_reg  <= tlen_next;
            open_reg  <= open_next;
        end
    end

endmodule

### rtl/ckm_queue.sv
// ckm_queue: short FIFO of per-line records between front and back.
// Depends on ckm_pkg for the default depth.
module ckm_queue #(
    parameter int W     = 8,
    parameter int DEPTH = ckm_pkg::QueueDepthDefault,
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CntW = $clog2(DEPTH + 1)
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         q_valid,
    output logic [W-1:0] q_data
);

    logic [W-1:0]    mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;

    assign full    = (cnt_reg == CntW'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem[rd_ptr_reg];

    function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

### rtl/ckm_back.sv
// ckm_back: pops line records, picks the first full-length match and
// holds the result in an output register. Depends on ckm_pkg.
module ckm_back #(
    parameter int LINE_MAX     = ckm_pkg::LineMaxDefault,
    parameter int NUM_COMMANDS = ckm_pkg::NumCommandsDefault,
    parameter int NAME_MAX     = ckm_pkg::NameMaxDefault,
    localparam int CntW = $clog2(LINE_MAX + 2),
    localparam int IdxW = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1,
    localparam int RecW = 1 + CntW + NUM_COMMANDS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  logic [RecW-1:0] q_data,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      line_status,
    output logic [4:0]      command_index,
    output logic [5:0]      token_length
);

    logic                    rec_over;
    logic [CntW-1:0]         rec_len;
    logic [NUM_COMMANDS-1:0] rec_mask;
    logic [NUM_COMMANDS-1:0] hit;
    logic                    any_hit;
    logic [IdxW-1:0]         hit_idx;
    logic [IdxW+4:0]         idx_wide;
    logic [CntW+5:0]         len_wide;

    ckm_pkg::line_status_t status_next;
    logic [4:0]            index_next;
    logic [5:0]            length_next;

    logic                  valid_reg;
    ckm_pkg::line_status_t status_reg;
    logic [4:0]            index_reg;
    logic [5:0]            length_reg;

    assign {rec_over, rec_len, rec_mask} = q_data;

    for (genvar k = 0; k < NUM_COMMANDS; k++)
    begin : g_hit
        localparam int EffLen = ckm_pkg::eff_len(k, NAME_MAX);
        assign hit[k] = rec_mask[k] && (rec_len == CntW'(EffLen));
    end

    always_comb
    begin
        hit_idx = '0;
        for (int k = NUM_COMMANDS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                hit_idx = IdxW'(k);
            end
        end
    end

    assign any_hit  = |hit;
    assign idx_wide = {5'b0, hit_idx};
    assign len_wide = {6'b0, rec_len};

    always_comb
    begin
        status_next = ckm_pkg::ST_NOT_FOUND;
        index_next  = '0;
        length_next = len_wide[5:0];
        if (rec_over)
        begin
            status_next = ckm_pkg::ST_OVERSHOOT;
            length_next = '0;
        end
        else if (rec_len == '0)
        begin
            status_next = ckm_pkg::ST_EMPTY;
        end
        else if (any_hit)
        begin
            status_next = ckm_pkg::ST_FOUND;
            index_next  = idx_wide[4:0];
        end
    end

    assign pop = q_valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            length_reg <= length_next;
        end
    end

    assign out_valid     = valid_reg;
    assign line_status   = status_reg;
    assign command_index = index_reg;
    assign token_length  = length_reg;

`ifndef SYNTHESIS
    a_overshoot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg == ckm_pkg::ST_OVERSHOOT)
            |-> (index_reg == '0 && length_reg == '0))
        else $error("overshoot result carries index or length");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg == ckm_pkg::ST_EMPTY)
            |-> (index_reg == '0 && length_reg == '0))
        else $error("empty result carries index or length");
    a_load_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(q_valid))
        else $error("result raised without a queued record");
    a_notfound_len: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg == ckm_pkg::ST_NOT_FOUND) |-> (index_reg == '0))
        else $error("not-found result carries an index");
`endif

endmodule

### rtl/command_keyword_matcher_unit.sv
// command_keyword_matcher_unit: top level of the console keyword matcher.
// Instantiates ckm_front, ckm_queue and ckm_back; depends on ckm_pkg.
//
//   channel | signals                                       | direction
//   --------+-----------------------------------------------+----------
//   input   | in_valid, in_ready, char_code[7:0]            | in
//   output  | out_valid, out_ready, line_status[1:0],       | out
//           | command_index[4:0], token_length[5:0]         |
//
// One character per cycle; every command name is compared in parallel.
// out_valid for a newline's result rises after the record passes the line queue and
// output register, later when the output register or two-entry line queue is full.
// Only a newline waits for queue space; other characters are always taken.
// Reset (rst_n low, asynchronous) clears the line state and empties the queue.
module command_keyword_matcher_unit #(
    parameter int LINE_MAX     = ckm_pkg::LineMaxDefault,
    parameter int NUM_COMMANDS = ckm_pkg::NumCommandsDefault,
    parameter int NAME_MAX     = ckm_pkg::NameMaxDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] line_status,
    output logic [4:0] command_index,
    output logic [5:0] token_length
);

    localparam int CntW = $clog2(LINE_MAX + 2);
    localparam int RecW = 1 + CntW + NUM_COMMANDS;

    logic            push, pop, q_full, q_valid;
    logic [RecW-1:0] push_data, q_data;

    ckm_front #(
        .LINE_MAX     (LINE_MAX),
        .NUM_COMMANDS (NUM_COMMANDS),
        .NAME_MAX     (NAME_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    ckm_queue #(
        .W     (RecW),
        .DEPTH (ckm_pkg::QueueDepthDefault)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    ckm_back #(
        .LINE_MAX     (LINE_MAX),
        .NUM_COMMANDS (NUM_COMMANDS),
        .NAME_MAX     (NAME_MAX)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .line_status   (line_status),
        .command_index (command_index),
        .token_length  (token_length)
    );

endmodule
